### hdl/tpa_pkg.sv
package tpa_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] CFG_MODE     = 2'd0;
	localparam logic [1:0] CFG_INTERVAL = 2'd1;
	localparam logic [1:0] CFG_METRIC   = 2'd2;

	// operating modes
	localparam logic [1:0] MODE_DEBOUNCE  = 2'd0;
	localparam logic [1:0] MODE_SAMPLE    = 2'd1;
	localparam logic [1:0] MODE_AGGREGATE = 2'd2;
	localparam logic [1:0] MODE_DROPOUT   = 2'd3;

	// aggregate metrics
	localparam logic [2:0] MET_AVG   = 3'd0;
	localparam logic [2:0] MET_SUM   = 3'd1;
	localparam logic [2:0] MET_MIN   = 3'd2;
	localparam logic [2:0] MET_MAX   = 3'd3;
	localparam logic [2:0] MET_COUNT = 3'd4;
	localparam logic [2:0] MET_RATE  = 3'd5;

	// result kinds
	localparam logic [1:0] KIND_PUBLISH = 2'd0;
	localparam logic [1:0] KIND_LOST    = 2'd1;
	localparam logic [1:0] KIND_FOUND   = 2'd2;

	localparam logic       CMD_TICK  = 1'b0;
	localparam logic       CMD_EVENT = 1'b1;

	localparam int TIME_W     = 48;
	localparam int IVAL_W     = 32;
	localparam int VAL_W      = 32;
	localparam int CNT_W      = 16;
	localparam int DIV_STEPS  = TIME_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	localparam logic [31:0] IVAL_RESET = 32'd1000;
	localparam logic [9:0]  MS_PER_S   = 10'd1000;

	typedef struct packed {
		logic                     cmd;
		logic [TIME_W-1:0]        now_ms;
		logic signed [VAL_W-1:0]  value;
	} evt_t;

	typedef struct packed {
		logic [1:0]               event_kind;
		logic signed [VAL_W-1:0]  result_value;
	} res_t;

	typedef struct packed {
		logic                     start;
		logic [TIME_W-1:0]        num;
		logic [IVAL_W-1:0]        den;
	} div_req_t;

endpackage

### hdl/tpa_div.sv
module tpa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpa_pkg::div_req_t             req,
	output logic                          done,
	output logic [tpa_pkg::TIME_W-1:0]    quot
);

	logic [tpa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [tpa_pkg::TIME_W-1:0]    q_q;
	logic [tpa_pkg::IVAL_W-1:0]    rem_q;
	logic [tpa_pkg::IVAL_W-1:0]    den_q;
	logic [tpa_pkg::IVAL_W:0]      rem_sh;
	logic [tpa_pkg::IVAL_W+1:0]    diff;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, q_q[tpa_pkg::TIME_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= tpa_pkg::DIV_CNT_W'(tpa_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tpa_pkg::DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			if (!diff[tpa_pkg::IVAL_W+1]) begin
				rem_q <= diff[tpa_pkg::IVAL_W-1:0];
				q_q   <= {q_q[tpa_pkg::TIME_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[tpa_pkg::IVAL_W-1:0];
				q_q   <= {q_q[tpa_pkg::TIME_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

### hdl/timed_publish_aggregator_core.sv
// Timed publish channel with four modes (debounce, sample, aggregate, dropout
// watchdog) selected by register mode; interval_ms sets the delay or period
// (0 acts as 1) and metric picks the aggregate result. Each evt transaction is
// a tick (cmd 0) or a data event (cmd 1) at time now_ms; a res transaction
// carries at most one published value, "lost" or "found" per input. Values
// are signed Q16.16 and published values saturate to 32 bits. Timing: the
// block takes one input at a time and holds evt_stall high until its work is
// done. An event, or a tick in debounce, sample or dropout mode or for the
// sum, min, max and count metrics, goes through S_EXEC (then S_EMIT if it
// publishes). Aggregate avg and rate publishes run through a shared 48-step
// restoring divider via S_PREP and S_DIV, then S_EMIT. The res output is a
// register, so a waiting result only blocks when the next result is ready.
// The user writes configuration through cfg only while idle; the block does
// not enforce it: cfg_ready is always high and writes take effect at once.
module timed_publish_aggregator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               evt_valid,
	output logic               evt_stall,
	input  tpa_pkg::evt_t      evt,
	output logic               res_valid,
	input  logic               res_stall,
	output tpa_pkg::res_t      res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PREP,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [1:0]                        mode_q;
	logic [tpa_pkg::IVAL_W-1:0]        interval_q;
	logic [2:0]                        metric_q;

	// channel state
	logic                              armed_q;
	logic                              started_q;
	logic                              lost_q;
	logic [tpa_pkg::TIME_W-1:0]        deadline_q;
	logic signed [tpa_pkg::VAL_W-1:0]  held_q;
	logic signed [tpa_pkg::TIME_W-1:0] sum_q;
	logic signed [tpa_pkg::VAL_W-1:0]  min_q;
	logic signed [tpa_pkg::VAL_W-1:0]  max_q;
	logic [tpa_pkg::CNT_W-1:0]         cnt_q;

	// captured transaction
	logic                              cmd_q;
	logic [tpa_pkg::TIME_W-1:0]        now_q;
	logic signed [tpa_pkg::VAL_W-1:0]  val_q;

	// divider operands and pending result
	logic [tpa_pkg::TIME_W-1:0]        num_q;
	logic [tpa_pkg::IVAL_W-1:0]        add_q;
	logic [tpa_pkg::IVAL_W-1:0]        den_q;
	logic                              neg_q;
	tpa_pkg::res_t                     pend_q;
	tpa_pkg::res_t                     res_q;
	logic                              res_valid_q;

	logic [tpa_pkg::IVAL_W-1:0]        iv_eff;
	logic [tpa_pkg::TIME_W-1:0]        next_dl;
	logic [tpa_pkg::TIME_W-1:0]        adv_dl;
	logic                              due;
	logic signed [tpa_pkg::TIME_W-1:0] val_ext;
	logic [tpa_pkg::TIME_W-1:0]        sum_mag;
	logic signed [tpa_pkg::VAL_W-1:0]  sum_sat;
	logic signed [tpa_pkg::VAL_W-1:0]  cnt_sat;
	logic [25:0]                       cnt_ms;
	logic                              slot_free;
	logic                              in_acc;
	logic                              cfg_acc;
	tpa_pkg::div_req_t                 div_req;
	logic                              div_done;
	logic [tpa_pkg::TIME_W-1:0]        div_quot;
	logic signed [tpa_pkg::VAL_W-1:0]  div_res;

	assign iv_eff  = (interval_q == '0) ? tpa_pkg::IVAL_W'(1) : interval_q;
	assign next_dl = now_q + {{(tpa_pkg::TIME_W-tpa_pkg::IVAL_W){1'b0}}, iv_eff};
	assign adv_dl  = deadline_q + {{(tpa_pkg::TIME_W-tpa_pkg::IVAL_W){1'b0}}, iv_eff};
	assign due     = armed_q && (now_q >= deadline_q);
	assign val_ext = {{(tpa_pkg::TIME_W-tpa_pkg::VAL_W){val_q[tpa_pkg::VAL_W-1]}}, val_q};

	// bucket magnitude for the avg path; the sum never reaches -2^47
	assign sum_mag = sum_q[tpa_pkg::TIME_W-1] ? tpa_pkg::TIME_W'(-sum_q)
	                                          : tpa_pkg::TIME_W'(sum_q);

	// sum saturates unless the upper 17 bits are all sign
	always_comb begin
		if (sum_q[tpa_pkg::TIME_W-1:tpa_pkg::VAL_W-1] == '0 ||
		    sum_q[tpa_pkg::TIME_W-1:tpa_pkg::VAL_W-1] == '1) begin
			sum_sat = sum_q[tpa_pkg::VAL_W-1:0];
		end else if (sum_q[tpa_pkg::TIME_W-1]) begin
			sum_sat = 32'sh8000_0000;
		end else begin
			sum_sat = 32'sh7fff_ffff;
		end
	end

	// count << 16, saturated once count reaches 32768
	assign cnt_sat = cnt_q[tpa_pkg::CNT_W-1] ? 32'sh7fff_ffff : {cnt_q, 16'h0000};

	// count * 1000 for the rate metric (constant multiply)
	assign cnt_ms = 26'(cnt_q * tpa_pkg::MS_PER_S);

	// signed saturation of the divider quotient
	always_comb begin
		if (neg_q) begin
			if (div_quot > 48'h0000_8000_0000) begin
				div_res = 32'sh8000_0000;
			end else begin
				div_res = -div_quot[tpa_pkg::VAL_W-1:0];
			end
		end else begin
			if (div_quot > 48'h0000_7fff_ffff) begin
				div_res = 32'sh7fff_ffff;
			end else begin
				div_res = div_quot[tpa_pkg::VAL_W-1:0];
			end
		end
	end

	assign div_req.start = (state_q == S_PREP);
	assign div_req.num   = num_q + {{(tpa_pkg::TIME_W-tpa_pkg::IVAL_W){1'b0}}, add_q};
	assign div_req.den   = den_q;

	tpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign evt_stall = (state_q != S_IDLE);
	assign in_acc    = evt_valid && !evt_stall;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign slot_free = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= tpa_pkg::MODE_DEBOUNCE;
			interval_q  <= tpa_pkg::IVAL_RESET;
			metric_q    <= tpa_pkg::MET_AVG;
			armed_q     <= 1'b0;
			started_q   <= 1'b0;
			lost_q      <= 1'b0;
			deadline_q  <= '0;
			held_q      <= '0;
			sum_q       <= '0;
			min_q       <= '0;
			max_q       <= '0;
			cnt_q       <= '0;
			num_q       <= '0;
			add_q       <= '0;
			den_q       <= '0;
			neg_q       <= 1'b0;
			pend_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_acc) begin
				case (cfg_index)
					tpa_pkg::CFG_MODE:     mode_q     <= cfg_wdata[1:0];
					tpa_pkg::CFG_INTERVAL: interval_q <= cfg_wdata;
					tpa_pkg::CFG_METRIC:   metric_q   <= cfg_wdata[2:0];
					default: ;
				endcase
			end

			// S_EMIT reloads the output itself
			if (res_valid_q && !res_stall && state_q != S_EMIT) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_EXEC;
					end
				end

				S_EXEC: begin
					state_q <= S_IDLE;
					if (cmd_q == tpa_pkg::CMD_EVENT) begin
						case (mode_q)
							tpa_pkg::MODE_DEBOUNCE: begin
								held_q     <= val_q;
								armed_q    <= 1'b1;
								started_q  <= 1'b1;
								deadline_q <= next_dl;
							end
							tpa_pkg::MODE_SAMPLE: begin
								held_q    <= val_q;
								armed_q   <= 1'b1;
								started_q <= 1'b1;
								if (!started_q) deadline_q <= next_dl;
							end
							tpa_pkg::MODE_AGGREGATE: begin
								// full bucket drops the event entirely
								if (cnt_q != '1) begin
									armed_q   <= 1'b1;
									started_q <= 1'b1;
									if (!started_q) deadline_q <= next_dl;
									if (cnt_q == '0) begin
										min_q <= val_q;
										max_q <= val_q;
									end else begin
										if (val_q < min_q) min_q <= val_q;
										if (val_q > max_q) max_q <= val_q;
									end
									sum_q <= sum_q + val_ext;
									cnt_q <= cnt_q + 1'b1;
								end
							end
							default: begin
								armed_q    <= 1'b1;
								started_q  <= 1'b1;
								deadline_q <= next_dl;
								if (lost_q) begin
									lost_q              <= 1'b0;
									pend_q.event_kind   <= tpa_pkg::KIND_FOUND;
									pend_q.result_value <= '0;
									state_q             <= S_EMIT;
								end
							end
						endcase
					end else if (due) begin
						case (mode_q)
							tpa_pkg::MODE_DROPOUT: begin
								lost_q              <= 1'b1;
								armed_q             <= 1'b0;
								pend_q.event_kind   <= tpa_pkg::KIND_LOST;
								pend_q.result_value <= '0;
								state_q             <= S_EMIT;
							end
							tpa_pkg::MODE_DEBOUNCE: begin
								armed_q             <= 1'b0;
								pend_q.event_kind   <= tpa_pkg::KIND_PUBLISH;
								pend_q.result_value <= held_q;
								state_q             <= S_EMIT;
							end
							tpa_pkg::MODE_SAMPLE: begin
								deadline_q          <= adv_dl;
								pend_q.event_kind   <= tpa_pkg::KIND_PUBLISH;
								pend_q.result_value <= held_q;
								state_q             <= S_EMIT;
							end
							default: begin
								deadline_q <= adv_dl;
								if (cnt_q != '0) begin
									// bucket is consumed here; the divider path
									// works from captured operands
									sum_q             <= '0;
									min_q             <= '0;
									max_q             <= '0;
									cnt_q             <= '0;
									pend_q.event_kind <= tpa_pkg::KIND_PUBLISH;
									case (metric_q)
										tpa_pkg::MET_AVG: begin
											num_q   <= sum_mag;
											add_q   <= tpa_pkg::IVAL_W'(cnt_q >> 1);
											den_q   <= tpa_pkg::IVAL_W'(cnt_q);
											neg_q   <= sum_q[tpa_pkg::TIME_W-1];
											state_q <= S_PREP;
										end
										tpa_pkg::MET_SUM: begin
											pend_q.result_value <= sum_sat;
											state_q             <= S_EMIT;
										end
										tpa_pkg::MET_MIN: begin
											pend_q.result_value <= min_q;
											state_q             <= S_EMIT;
										end
										tpa_pkg::MET_MAX: begin
											pend_q.result_value <= max_q;
											state_q             <= S_EMIT;
										end
										tpa_pkg::MET_COUNT: begin
											pend_q.result_value <= cnt_sat;
											state_q             <= S_EMIT;
										end
										tpa_pkg::MET_RATE: begin
											num_q   <= {6'b0, cnt_ms, 16'h0000};
											add_q   <= iv_eff >> 1;
											den_q   <= iv_eff;
											neg_q   <= 1'b0;
											state_q <= S_PREP;
										end
										default: ;
									endcase
								end
							end
						endcase
					end
				end

				S_PREP: begin
					state_q <= S_DIV;
				end

				S_DIV: begin
					if (div_done) begin
						pend_q.result_value <= div_res;
						state_q             <= S_EMIT;
					end
				end

				S_EMIT: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= evt.cmd;
			now_q <= evt.now_ms;
			val_q <= evt.value;
		end
		if (state_q == S_EMIT && slot_free) begin
			res_q <= pend_q;
		end
	end

endmodule
